// File: design/locd_pkg.sv
// shared types and constants for the lock order cycle detector
// no dependencies
package locd_pkg;

  localparam int ID_W     = 5;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_DEADLOCK  = 3'd1,
    STS_EMPTY_REL = 3'd2,
    STS_NOT_TOP   = 3'd3,
    STS_OVERFLOW  = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP,
    ST_GCHK,
    ST_ROOT,
    ST_ROW,
    ST_SCAN,
    ST_FRM,
    ST_FIN,
    ST_RESP
  } state_t;

endpackage

// File: design/locd_if.sv
// valid/ready channel interfaces for event beats and result beats
// depends on locd_pkg
interface locd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [locd_pkg::ID_W-1:0] lock_id;
  modport source (output valid, output command, output lock_id, input ready);
  modport sink   (input valid, input command, input lock_id, output ready);
endinterface

interface locd_out_if;
  logic                          valid;
  logic                          ready;
  logic [locd_pkg::STATUS_W-1:0] status;
  logic [locd_pkg::ID_W-1:0]     edge_from;
  logic [locd_pkg::ID_W-1:0]     edge_to;
  logic [locd_pkg::ID_W-1:0]     stack_level;
  modport source (output valid, output status, output edge_from, output edge_to,
                  output stack_level, input ready);
  modport sink   (input valid, input status, input edge_from, input edge_to,
                  input stack_level, output ready);
endinterface

// File: design/locd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module locd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/lock_order_cycle_detector.sv
// lock order cycle detector top level: held stack, order graph, dfs sequencer
// depends on locd_pkg, locd_if, locd_ram
//
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid/ready        | command, lock_id
//  out_ch  | out | valid/ready        | status, edge_from, edge_to, stack_level
//
// a release or an acquire that adds no edge skips the dfs
// an acquire with a new edge runs a dfs that scans one adjacency bit per cycle,
// pausing to fetch a row on each descent, each return and each new root
// rst_n clears stack count, graph row valid bits and control; no clearing pass
// in_ch.ready is high only in idle; a held result does not block the next beat
module lock_order_cycle_detector #(
  parameter int LOCK_COUNT  = 32,
  parameter int STACK_DEPTH = 16
) (
  input logic           clk,
  input logic           rst_n,
  locd_in_if.sink       in_ch,
  locd_out_if.source    out_ch
);
  import locd_pkg::*;

  localparam int IW  = $clog2(LOCK_COUNT);
  localparam int NW  = $clog2(LOCK_COUNT + 1);
  localparam int SW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW  = IW + NW;

  state_t                state_r, state_nxt;
  logic                  cmd_r, cmd_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [SW-1:0]         held_count_r, held_count_nxt;
  logic [LOCK_COUNT-1:0] row_r, row_nxt;
  logic [IW-1:0]         here_r, here_nxt;
  logic [NW-1:0]         next_r, next_nxt;
  logic [NW-1:0]         depth_r, depth_nxt;
  logic [NW-1:0]         root_r, root_nxt;
  logic [LOCK_COUNT-1:0] seen_r, seen_nxt;
  logic [LOCK_COUNT-1:0] done_r, done_nxt;
  logic [LOCK_COUNT-1:0] row_vld_r, row_vld_nxt;
  logic                  gvld_q_r;
  status_t               st_r, st_nxt;
  logic [ID_W-1:0]       ef_r, ef_nxt, et_r, et_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [ID_W-1:0]       out_from_r, out_from_nxt, out_to_r, out_to_nxt;
  logic [ID_W-1:0]       out_level_r, out_level_nxt;

  // memory ports
  logic                  s_we;
  logic [SAW-1:0]        s_waddr, s_raddr;
  logic [ID_W-1:0]       s_wdata, s_rdata;
  logic                  g_we;
  logic [IW-1:0]         g_waddr, g_raddr;
  logic [LOCK_COUNT-1:0] g_wdata, g_rdata, g_row;
  logic                  f_we;
  logic [IW-1:0]         f_waddr, f_raddr;
  logic [FW-1:0]         f_wdata, f_rdata;

  logic [SW-1:0]         cnt_m1;
  logic [IW-1:0]         id_node, top_node, n_node;
  logic [NW-1:0]         depth_m2;

  locd_ram #(.WIDTH(ID_W), .DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  locd_ram #(.WIDTH(LOCK_COUNT), .DEPTH(LOCK_COUNT), .AW(IW)) u_graph (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  locd_ram #(.WIDTH(FW), .DEPTH(LOCK_COUNT), .AW(IW)) u_frames (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  assign cnt_m1   = held_count_r - SW'(1);
  assign id_node  = IW'(id_r);
  assign top_node = IW'(s_rdata);
  assign n_node   = next_r[IW-1:0];
  assign depth_m2 = depth_r - NW'(2);
  // rows never written read as zero
  assign g_row    = gvld_q_r ? g_rdata : '0;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.edge_from   = out_from_r;
  assign out_ch.edge_to     = out_to_r;
  assign out_ch.stack_level = out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_count_r <= '0;
      row_vld_r    <= '0;
      out_valid_r  <= 1'b0;
      depth_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      held_count_r <= held_count_nxt;
      row_vld_r    <= row_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      depth_r      <= depth_nxt;
    end
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    row_r        <= row_nxt;
    here_r       <= here_nxt;
    next_r       <= next_nxt;
    root_r       <= root_nxt;
    seen_r       <= seen_nxt;
    done_r       <= done_nxt;
    gvld_q_r     <= row_vld_r[g_raddr];
    st_r         <= st_nxt;
    ef_r         <= ef_nxt;
    et_r         <= et_nxt;
    out_status_r <= out_status_nxt;
    out_from_r   <= out_from_nxt;
    out_to_r     <= out_to_nxt;
    out_level_r  <= out_level_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    held_count_nxt = held_count_r;
    row_nxt        = row_r;
    here_nxt       = here_r;
    next_nxt       = next_r;
    depth_nxt      = depth_r;
    root_nxt       = root_r;
    seen_nxt       = seen_r;
    done_nxt       = done_r;
    row_vld_nxt    = row_vld_r;
    st_nxt         = st_r;
    ef_nxt         = ef_r;
    et_nxt         = et_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_from_nxt   = out_from_r;
    out_to_nxt     = out_to_r;
    out_level_nxt  = out_level_r;
    s_we    = 1'b0;
    s_waddr = held_count_r[SAW-1:0];
    s_wdata = id_r;
    s_raddr = cnt_m1[SAW-1:0];
    g_we    = 1'b0;
    g_waddr = top_node;
    g_wdata = '0;
    g_raddr = here_r;
    f_we    = 1'b0;
    f_waddr = IW'(depth_r - NW'(1));
    f_wdata = {here_r, next_r + NW'(1)};
    f_raddr = depth_m2[IW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.command;
          id_nxt  = in_ch.lock_id;
          st_nxt  = STS_OK;
          ef_nxt  = '0;
          et_nxt  = '0;
          if (held_count_r != '0) begin
            state_nxt = ST_TOP;
          end else if (in_ch.command == CMD_RELEASE) begin
            st_nxt    = STS_EMPTY_REL;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_TOP: begin
        g_raddr = top_node;
        here_nxt = top_node;
        if (cmd_r == CMD_RELEASE) begin
          if (s_rdata != id_r) begin
            st_nxt = STS_NOT_TOP;
          end else begin
            held_count_nxt = cnt_m1;
          end
          state_nxt = ST_RESP;
        end else if (s_rdata != id_r && 32'(s_rdata) < LOCK_COUNT &&
                     32'(id_r) < LOCK_COUNT) begin
          state_nxt = ST_GCHK;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_GCHK: begin
        if (g_row[id_node]) begin
          state_nxt = ST_FIN;
        end else begin
          g_we    = 1'b1;
          g_waddr = here_r;
          g_wdata = g_row | (LOCK_COUNT'(1) << id_node);
          row_vld_nxt[here_r] = 1'b1;
          seen_nxt  = '0;
          done_nxt  = '0;
          root_nxt  = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        g_raddr = root_r[IW-1:0];
        if (root_r == NW'(LOCK_COUNT)) begin
          state_nxt = ST_FIN;
        end else if (seen_r[root_r[IW-1:0]]) begin
          root_nxt = root_r + NW'(1);
        end else begin
          seen_nxt[root_r[IW-1:0]] = 1'b1;
          here_nxt  = root_r[IW-1:0];
          next_nxt  = '0;
          depth_nxt = NW'(1);
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        row_nxt   = g_row;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        g_raddr = n_node;
        if (next_r == NW'(LOCK_COUNT)) begin
          // node finished, pop its frame
          done_nxt[here_r] = 1'b1;
          depth_nxt = depth_r - NW'(1);
          if (depth_r == NW'(1)) begin
            root_nxt  = root_r + NW'(1);
            state_nxt = ST_ROOT;
          end else begin
            state_nxt = ST_FRM;
          end
        end else if (row_r[n_node]) begin
          if (!seen_r[n_node]) begin
            seen_nxt[n_node] = 1'b1;
            f_we      = 1'b1;
            here_nxt  = n_node;
            next_nxt  = '0;
            depth_nxt = depth_r + NW'(1);
            state_nxt = ST_ROW;
          end else if (!done_r[n_node]) begin
            // still on the walk path: back edge
            st_nxt    = STS_DEADLOCK;
            ef_nxt    = ID_W'(here_r);
            et_nxt    = ID_W'(n_node);
            state_nxt = ST_RESP;
          end else begin
            next_nxt = next_r + NW'(1);
          end
        end else begin
          next_nxt = next_r + NW'(1);
        end
      end
      ST_FRM: begin
        here_nxt  = f_rdata[FW-1:NW];
        next_nxt  = f_rdata[NW-1:0];
        g_raddr   = f_rdata[FW-1:NW];
        state_nxt = ST_ROW;
      end
      ST_FIN: begin
        if (held_count_r >= SW'(STACK_DEPTH)) begin
          st_nxt = STS_OVERFLOW;
        end else begin
          s_we           = 1'b1;
          held_count_nxt = held_count_r + SW'(1);
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_from_nxt   = ef_r;
          out_to_nxt     = et_r;
          out_level_nxt  = ID_W'(held_count_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= SW'(STACK_DEPTH))
    else $error("held count beyond stack depth");

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= NW'(LOCK_COUNT) || state_r == ST_IDLE)
    else $error("walk depth beyond lock count");

  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STS_DEADLOCK |-> out_from_r == '0 && out_to_r == '0)
    else $error("edge fields set without deadlock");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != ST_IDLE)
    else $error("sequencer idle right after accept");
`endif

endmodule

// File: tb/sv/locd_tb_if.sv
`timescale 1ns / 1ps
// interfaces for the testbench side are the design's locd_in_if and locd_out_if
// this file holds the event and verdict item types shared by the testbench; depends on locd_pkg
package locd_tb_pkg;
  import locd_pkg::*;

  typedef struct packed {
    cmd_t             command;
    logic [ID_W-1:0]  lock_id;
  } lock_event_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  edge_from;
    logic [ID_W-1:0]  edge_to;
    logic [ID_W-1:0]  stack_level;
  } lock_verdict_t;

endpackage

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for lock_order_cycle_detector: drives lock events, predicts verdicts
// depends on locd_pkg, locd_if, locd_tb_pkg and the design
module tb;
  import locd_pkg::*;
  import locd_tb_pkg::*;

  localparam int NLOCK = 32;
  localparam int DEPTH = 16;

  class lock_order_scoreboard;
    logic [4:0]       held [DEPTH];
    int               held_n;
    logic [NLOCK-1:0] graph [NLOCK];
    lock_verdict_t    pending [$];
    int               errors;
    int               checked;
    int               deadlocks;

    function void clear();
      held_n = 0;
      errors = 0;
      checked = 0;
      deadlocks = 0;
      foreach (graph[i]) graph[i] = '0;
      foreach (held[i]) held[i] = '0;
    endfunction

    // full dfs, ascending roots and neighbors; first back edge wins
    function bit find_back_edge(output logic [4:0] from_id, output logic [4:0] to_id);
      bit seen [NLOCK];
      bit done [NLOCK];
      int rank_of [NLOCK];
      int fnode [NLOCK];
      int fnext [NLOCK];
      int rank, depth, here, n;
      rank = 0;
      from_id = '0;
      to_id = '0;
      for (int i = 0; i < NLOCK; i++) begin
        seen[i] = 0; done[i] = 0; rank_of[i] = 0;
      end
      for (int root = 0; root < NLOCK; root++) begin
        if (seen[root]) continue;
        seen[root] = 1;
        rank_of[root] = rank++;
        fnode[0] = root;
        fnext[0] = 0;
        depth = 1;
        while (depth > 0) begin
          here = fnode[depth-1];
          n = fnext[depth-1];
          while (n < NLOCK && !graph[here][n]) n++;
          if (n >= NLOCK) begin
            done[here] = 1;
            depth--;
            continue;
          end
          fnext[depth-1] = n + 1;
          if (!seen[n]) begin
            seen[n] = 1;
            rank_of[n] = rank++;
            if (depth < NLOCK) begin
              fnode[depth] = n;
              fnext[depth] = 0;
              depth++;
            end
            continue;
          end
          if (rank_of[here] < rank_of[n]) continue;
          if (!done[n]) begin
            from_id = 5'(here);
            to_id = 5'(n);
            return 1;
          end
        end
      end
      return 0;
    endfunction

    function void note_event(lock_event_t ev);
      lock_verdict_t v;
      logic [4:0] prev, f, t;
      v = '{status: STS_OK, edge_from: '0, edge_to: '0, stack_level: '0};
      if (ev.command == CMD_ACQUIRE) begin
        if (held_n > 0) begin
          prev = held[held_n-1];
          if (ev.lock_id != prev && !graph[prev][ev.lock_id]) begin
            graph[prev][ev.lock_id] = 1'b1;
            if (find_back_edge(f, t)) begin
              v.status = STS_DEADLOCK;
              v.edge_from = f;
              v.edge_to = t;
              deadlocks++;
            end
          end
        end
        if (v.status == STS_OK) begin
          if (held_n >= DEPTH) v.status = STS_OVERFLOW;
          else held[held_n++] = ev.lock_id;
        end
      end else begin
        if (held_n == 0) v.status = STS_EMPTY_REL;
        else if (held[held_n-1] != ev.lock_id) v.status = STS_NOT_TOP;
        else held_n--;
      end
      v.stack_level = held_n[4:0];
      pending.push_back(v);
    endfunction

    function void check_verdict(lock_verdict_t got);
      lock_verdict_t want;
      checked++;
      if (pending.size() == 0) begin
        $error("verdict with nothing pending: status %0d", got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.edge_from != want.edge_from) begin
        $error("edge_from: expected %0d, got %0d", want.edge_from, got.edge_from);
        errors++;
      end
      if (got.edge_to != want.edge_to) begin
        $error("edge_to: expected %0d, got %0d", want.edge_to, got.edge_to);
        errors++;
      end
      if (got.stack_level != want.stack_level) begin
        $error("stack_level: expected %0d, got %0d", want.stack_level, got.stack_level);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  locd_in_if  in_ch ();
  locd_out_if out_ch ();

  lock_order_cycle_detector #(.LOCK_COUNT(NLOCK), .STACK_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  lock_order_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  int sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, plus a long hold when asked
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        board.check_verdict('{status: status_t'(out_ch.status), edge_from: out_ch.edge_from,
                              edge_to: out_ch.edge_to, stack_level: out_ch.stack_level});
      if (recv_hold && hold_cnt == 0) hold_cnt = 3000;
      if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) recv_hold = 0;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // valid stays up after an accept until the next beat or an idle cycle replaces it
  task automatic send_event(input cmd_t c, input logic [4:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= c;
    in_ch.lock_id <= id;
    do @(posedge clk); while (!in_ch.ready);
    board.note_event('{command: c, lock_id: id});
    sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 2_000_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  // nesting: acquire a few locks (repeats allowed) then release them in reverse order, with the odd stray release
  task automatic nested_section(input int span);
    logic [4:0] ids [$];
    logic [4:0] id;
    for (int k = 0; k < span; k++) begin
      id = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
      send_event(CMD_ACQUIRE, id);
      if (board.pending[$].status == STS_OK) ids.push_back(id);
    end
    while (ids.size() != 0) begin
      if ($urandom_range(19) == 0) send_event(CMD_RELEASE, 5'($urandom_range(31)));
      send_event(CMD_RELEASE, ids.pop_back());
    end
  endtask

  initial begin
    board = new();
    board.clear();
    sent = 0;
    recv_hold = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_ACQUIRE;
    in_ch.lock_id <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty release, extreme ids, a two-lock cycle, not-top, overflow
    send_event(CMD_RELEASE, 5'd0);
    send_event(CMD_ACQUIRE, 5'd0);
    send_event(CMD_ACQUIRE, 5'd31);
    send_event(CMD_ACQUIRE, 5'd31);
    send_event(CMD_RELEASE, 5'd0);
    send_event(CMD_RELEASE, 5'd31);
    send_event(CMD_RELEASE, 5'd31);
    send_event(CMD_RELEASE, 5'd0);
    send_event(CMD_ACQUIRE, 5'd31);
    send_event(CMD_ACQUIRE, 5'd0);   // back edge closes a cycle
    send_event(CMD_RELEASE, 5'd31);
    send_event(CMD_ACQUIRE, 5'd10);
    send_event(CMD_ACQUIRE, 5'd21);
    send_event(CMD_ACQUIRE, 5'd21);  // same lock as the top: no edge is added
    send_event(CMD_RELEASE, 5'd21);
    send_event(CMD_RELEASE, 5'd21);
    send_event(CMD_RELEASE, 5'd10);
    for (int k = 0; k < 17; k++) send_event(CMD_ACQUIRE, 5'd1);  // fills, then overflows
    for (int k = 0; k < 16; k++) send_event(CMD_RELEASE, 5'd1);
    drain();

    // random phases with the three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 34 : 0;
      if (ph == 1) recv_hold = 1;
      while (sent < 70 + (ph + 1) * 170) begin
        if ($urandom_range(9) < 8) nested_section($urandom_range(1, 5));
        else send_event(cmd_t'($urandom_range(1)), 5'($urandom_range(31)));
      end
      drain();  // sender waits for every verdict
    end

    $display("covered %0d lock events, %0d verdicts checked, %0d deadlocks seen",
             sent, board.checked, board.deadlocks);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
